FILE: rtl/box_muller_gaussian_2d_top_defines.svh
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator: assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BOX_MULLER_GAUSSIAN_2D_TOP_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_2D_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication check
`define BMG_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");
// next-cycle implication check
`define BMG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define BMG_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define BMG_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/bmg_pkg.sv
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator package
// Fixed-point constants, stage counts and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bmg_pkg;

    // fixed-point constants (Q.30)
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0] TWO_LN2_Q30  = 31'd1488522236;
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;

    // datapath widths, sized for uniforms up to 32 bits
    localparam int T_W    = 36;          // log term, Q.30
    localparam int V_W    = 36;          // -2 ln term, Q.30
    localparam int N_W    = V_W + 18;    // square root operand
    localparam int S_W    = N_W / 2;     // square root, Q.24
    localparam int Z_W    = 28;          // |z|, Q.24
    localparam int D_W    = 20;          // scaled |z|, Q.8
    localparam int OUT_W  = 24;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 4;

    // stage counts
    localparam int SQ_STEPS     = 30;
    localparam int SQRT_STEPS   = S_W;
    localparam int HORNER_STEPS = 6;
    localparam int RAD_LAT      = 2 + SQ_STEPS + 3 + SQRT_STEPS;
    localparam int COS_LAT      = 3 + 3 * HORNER_STEPS + 1;
    localparam int AX_LAT       = RAD_LAT + 3;

    // Horner divisors and floor(2^32 / k)
    localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] =
        '{32'd32537631, 32'd47721858, 32'd76695844,
          32'd143165576, 32'd357913941, 32'd2147483648};

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAN_X = 4'd0,
        REG_MEAN_Y = 4'd1,
        REG_STD_X  = 4'd2,
        REG_STD_Y  = 4'd3
    } cfg_reg_t;

    // per-axis scaling
    typedef struct packed {
        logic signed [CFG_W-1:0] mean;
        logic        [CFG_W-1:0] std;
    } axis_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/bmg_channels_if.sv
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator channels
// Uniform request, sample result and register write interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmg_in_if #(
    parameter int UNIFORM_BITS = 16
) ();
    logic                    valid;
    logic                    ready;
    logic [UNIFORM_BITS-1:0] radius_uniform_x;
    logic [UNIFORM_BITS-1:0] angle_uniform_x;
    logic [UNIFORM_BITS-1:0] radius_uniform_y;
    logic [UNIFORM_BITS-1:0] angle_uniform_y;

    modport source (
        output valid, radius_uniform_x, angle_uniform_x,
               radius_uniform_y, angle_uniform_y,
        input  ready
    );
    modport sink (
        input  valid, radius_uniform_x, angle_uniform_x,
               radius_uniform_y, angle_uniform_y,
        output ready
    );
endinterface

interface bmg_out_if import bmg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_x;
    logic signed [OUT_W-1:0] sample_y;

    modport source (output valid, sample_x, sample_y, input ready);
    modport sink (input valid, sample_x, sample_y, output ready);
endinterface

interface bmg_cfg_if import bmg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bmg_axis.sv
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator: one axis
// Pipelined log2, square root, cosine and scaling for one normal sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bmg_axis import bmg_pkg::*; #(
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [UNIFORM_BITS-1:0] radius,
    input  wire logic [UNIFORM_BITS-1:0] angle,
    input  wire axis_cfg_t               cfg,
    output logic signed [OUT_W-1:0]      sample
);

    localparam int M_W   = UNIFORM_BITS + 1;
    localparam int E_W   = $clog2(UNIFORM_BITS + 1);
    localparam int PHI_W = T_W - 30 + 31;
    localparam int DLY   = RAD_LAT - COS_LAT;
    localparam logic [T_W-1:0] FULL_LOG = T_W'(UNIFORM_BITS) << 30;

    typedef struct packed {
        logic [31:0] x2;
        logic        quad_neg;
    } hcarry_t;

    // ---------------- radius path ----------------
    logic [M_W-1:0]      m_reg;
    logic [E_W-1:0]      lead_next;
    logic [M_W+30:0]     norm_wide;
    logic [31:0]         y_reg  [SQ_STEPS+1];
    logic [E_W-1:0]      e_reg  [SQ_STEPS+1];
    logic [SQ_STEPS-1:0] fr_reg [SQ_STEPS+1];
    logic [T_W-1:0]      lg_next;
    logic [T_W-1:0]      t_reg;
    logic [PHI_W-1:0]    phi_reg;
    logic [30:0]         plo_reg;
    logic [V_W-1:0]      v_reg;
    logic [N_W-1:0]      sr_rem  [SQRT_STEPS+1];
    logic [S_W-1:0]      sr_root [SQRT_STEPS+1];

    // form 2^U - r
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, radius};
        end
    end

    // find the leading one and normalize to Q.31
    always_comb
    begin
        lead_next = '0;
        for (int i = 0; i < M_W; i++)
        begin
            if (m_reg[i])
            begin
                lead_next = E_W'(i);
            end
        end
        norm_wide = {m_reg, 31'b0} >> lead_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0]  <= norm_wide[31:0];
            e_reg[0]  <= lead_next;
            fr_reg[0] <= '0;
        end
    end

    // one fraction bit per squaring stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic [63:0] sq_next;

        always_comb
        begin
            sq_next = 64'(y_reg[k]) * 64'(y_reg[k]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_next[63])
                begin
                    y_reg[k+1]  <= sq_next[63:32];
                    fr_reg[k+1] <= {fr_reg[k][SQ_STEPS-2:0], 1'b1};
                end
                else
                begin
                    y_reg[k+1]  <= sq_next[62:31];
                    fr_reg[k+1] <= {fr_reg[k][SQ_STEPS-2:0], 1'b0};
                end
                e_reg[k+1] <= e_reg[k];
            end
        end
    end

    // t = U - log2(m), clamped at zero
    always_comb
    begin
        lg_next = T_W'({e_reg[SQ_STEPS], fr_reg[SQ_STEPS]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= (lg_next >= FULL_LOG) ? '0 : FULL_LOG - lg_next;
            phi_reg <= PHI_W'(t_reg[T_W-1:30]) * PHI_W'(TWO_LN2_Q30);
            plo_reg <= 31'((61'(t_reg[29:0]) * 61'(TWO_LN2_Q30)) >> 30);
            v_reg   <= V_W'(phi_reg + PHI_W'(plo_reg));
        end
    end

    // restoring square root, one result bit per stage
    assign sr_rem[0]  = {v_reg, 18'b0};
    assign sr_root[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam int BIT = SQRT_STEPS - 1 - j;
        logic [N_W:0] trial_next;

        always_comb
        begin
            trial_next = ((N_W+1)'(sr_root[j]) << (BIT + 1))
                       + ((N_W+1)'(1) << (2 * BIT));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ((N_W+1)'(sr_rem[j]) >= trial_next)
                begin
                    sr_rem[j+1]  <= sr_rem[j] - trial_next[N_W-1:0];
                    sr_root[j+1] <= sr_root[j] | (S_W'(1) << BIT);
                end
                else
                begin
                    sr_rem[j+1]  <= sr_rem[j];
                    sr_root[j+1] <= sr_root[j];
                end
            end
        end
    end

    // ---------------- angle path ----------------
    logic [31:0]        ph_next;
    logic [30:0]        g_reg;
    logic               qn_reg;
    logic [30:0]        x_reg;
    logic               xqn_reg;
    hcarry_t            hc0_reg;
    logic [31:0]        hw_reg  [HORNER_STEPS];
    logic [31:0]        hqe_reg [HORNER_STEPS];
    logic [31:0]        hwb_reg [HORNER_STEPS];
    logic signed [31:0] ht_reg  [HORNER_STEPS];
    hcarry_t            hca_reg [HORNER_STEPS];
    hcarry_t            hcb_reg [HORNER_STEPS];
    hcarry_t            hcc_reg [HORNER_STEPS];
    logic [30:0]        cmag_reg;
    logic               cneg_reg;
    logic [30:0]        dl_cmag_reg [DLY];
    logic               dl_neg_reg  [DLY];

    always_comb
    begin
        ph_next = 32'({angle, 32'b0} >> UNIFORM_BITS);
    end

    // fold the phase into a quarter turn, scale it to radians and square it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg   <= ph_next[30] ? (Q30_ONE - {1'b0, ph_next[29:0]})
                                   : {1'b0, ph_next[29:0]};
            qn_reg  <= ph_next[31] ^ ph_next[30];
            x_reg   <= 31'((62'(g_reg) * 62'(HALF_PI_Q30)) >> 30);
            xqn_reg <= qn_reg;
            hc0_reg.x2       <= 32'((62'(x_reg) * 62'(x_reg)) >> 30);
            hc0_reg.quad_neg <= xqn_reg;
        end
    end

    // Horner steps: multiply, reciprocal multiply, correct and subtract
    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_horner
        logic [30:0]   t_in;
        hcarry_t       c_in;
        logic [39:0]   back_next;
        logic [31:0]   rem_next;
        logic [31:0]   q_next;

        if (j == 0)
        begin : g_first
            assign t_in = Q30_ONE;
            assign c_in = hc0_reg;
        end
        else
        begin : g_rest
            assign t_in = ht_reg[j-1][30:0];
            assign c_in = hcc_reg[j-1];
        end

        always_comb
        begin
            back_next = 40'(hqe_reg[j]) * 40'(HORNER_DIV[j]);
            rem_next  = hwb_reg[j] - back_next[31:0];
            q_next    = hqe_reg[j] + 32'(rem_next >= 32'(HORNER_DIV[j]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hw_reg[j]  <= 32'((64'(c_in.x2) * 64'(t_in)) >> 30);
                hca_reg[j] <= c_in;
                hqe_reg[j] <= 32'((64'(hw_reg[j]) * 64'(HORNER_RECIP[j])) >> 32);
                hwb_reg[j] <= hw_reg[j];
                hcb_reg[j] <= hca_reg[j];
                ht_reg[j]  <= $signed({1'b0, Q30_ONE}) - $signed(q_next);
                hcc_reg[j] <= hcb_reg[j];
            end
        end
    end

    // split cosine into magnitude and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ht_reg[HORNER_STEPS-1][31])
            begin
                cmag_reg <= 31'(-ht_reg[HORNER_STEPS-1]);
                cneg_reg <= !hcc_reg[HORNER_STEPS-1].quad_neg;
            end
            else
            begin
                cmag_reg <= ht_reg[HORNER_STEPS-1][30:0];
                cneg_reg <= hcc_reg[HORNER_STEPS-1].quad_neg;
            end
        end
    end

    // delay cosine to meet the square root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_cmag_reg[0] <= cmag_reg;
            dl_neg_reg[0]  <= cneg_reg;
            for (int k = 1; k < DLY; k++)
            begin
                dl_cmag_reg[k] <= dl_cmag_reg[k-1];
                dl_neg_reg[k]  <= dl_neg_reg[k-1];
            end
        end
    end

    // ---------------- combine and scale ----------------
    logic [Z_W-1:0]          z_reg;
    logic                    zneg_reg;
    logic [D_W-1:0]          d_reg;
    logic                    dneg_reg;
    logic signed [OUT_W:0]   mean_ext;
    logic signed [OUT_W:0]   d_ext;
    logic signed [OUT_W:0]   sum_next;
    logic signed [OUT_W-1:0] sat_next;
    logic signed [OUT_W-1:0] sample_reg;

    always_comb
    begin
        mean_ext = {{(OUT_W+1-CFG_W){cfg.mean[CFG_W-1]}}, cfg.mean};
        d_ext    = {{(OUT_W+1-D_W){1'b0}}, d_reg};
        sum_next = dneg_reg ? (mean_ext - d_ext) : (mean_ext + d_ext);
        if (sum_next[OUT_W] != sum_next[OUT_W-1])
        begin
            sat_next = sum_next[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}}
                                       : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            sat_next = sum_next[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg      <= Z_W'((58'(sr_root[SQRT_STEPS]) * 58'(dl_cmag_reg[DLY-1])) >> 30);
            zneg_reg   <= dl_neg_reg[DLY-1];
            d_reg      <= D_W'((44'(z_reg) * 44'(cfg.std)) >> 24);
            dneg_reg   <= zneg_reg;
            sample_reg <= sat_next;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

FILE: rtl/box_muller_gaussian_2d_top.sv
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator, two axes
// Turns four uniform fractions into a scaled normal sample pair.
// ----------------------------------------------------------------------------
//  channel   role    handshake      payload
//  uniform   sink    valid/ready    radius/angle uniforms for x and y
//  sample    source  valid/ready    sample_x, sample_y (Q16.8, saturated)
//  cfg       sink    valid/ready    index, data (mean/std registers)
//
//  One request per cycle and one sample pair per cycle while the result is not
//  stalled; each axis holds 30 squaring stages of log2 and 27 square root stages.
//  A stalled result holds the whole pipeline; nothing is dropped.
//  Reset clears all valid bits and loads mean 0, deviation 1.0 on both axes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_muller_gaussian_2d_top_defines.svh"

module box_muller_gaussian_2d_top import bmg_pkg::*; #(
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmg_in_if.sink     uniform,
    bmg_out_if.source  sample,
    bmg_cfg_if.sink    cfg
);

    logic              pipe_en;
    logic [AX_LAT-1:0] vld_reg;
    logic [AX_LAT-1:0] vld_next;
    logic [CFG_W-1:0]  mean_x_reg, mean_x_next;
    logic [CFG_W-1:0]  mean_y_reg, mean_y_next;
    logic [CFG_W-1:0]  std_x_reg, std_x_next;
    logic [CFG_W-1:0]  std_y_reg, std_y_next;
    axis_cfg_t         cfg_x;
    axis_cfg_t         cfg_y;

    // advance when the output slot is free or being taken
    assign pipe_en       = !vld_reg[AX_LAT-1] || sample.ready;
    assign uniform.ready = pipe_en;
    assign sample.valid  = vld_reg[AX_LAT-1];
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        vld_next = pipe_en ? {vld_reg[AX_LAT-2:0], uniform.valid} : vld_reg;
    end

    // register writes
    always_comb
    begin
        mean_x_next = mean_x_reg;
        mean_y_next = mean_y_reg;
        std_x_next  = std_x_reg;
        std_y_next  = std_y_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MEAN_X: mean_x_next = cfg.data;
                REG_MEAN_Y: mean_y_next = cfg.data;
                REG_STD_X:  std_x_next  = cfg.data;
                REG_STD_Y:  std_y_next  = cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            mean_x_reg <= '0;
            mean_y_reg <= '0;
            std_x_reg  <= CFG_W'(256);
            std_y_reg  <= CFG_W'(256);
        end
        else
        begin
            vld_reg    <= vld_next;
            mean_x_reg <= mean_x_next;
            mean_y_reg <= mean_y_next;
            std_x_reg  <= std_x_next;
            std_y_reg  <= std_y_next;
        end
    end

    assign cfg_x = '{mean: $signed(mean_x_reg), std: std_x_reg};
    assign cfg_y = '{mean: $signed(mean_y_reg), std: std_y_reg};

    // one pipeline per axis
    bmg_axis #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_axis_x (
        .clk    (clk),
        .en     (pipe_en),
        .radius (uniform.radius_uniform_x),
        .angle  (uniform.angle_uniform_x),
        .cfg    (cfg_x),
        .sample (sample.sample_x)
    );

    bmg_axis #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_axis_y (
        .clk    (clk),
        .en     (pipe_en),
        .radius (uniform.radius_uniform_y),
        .angle  (uniform.angle_uniform_y),
        .cfg    (cfg_y),
        .sample (sample.sample_y)
    );

    // checks
    `BMG_ASSERT_NEXT(a_accept_enters, clk, rst_n, uniform.valid && uniform.ready, vld_reg[0])
    `BMG_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !pipe_en, $stable(vld_reg))
    `BMG_ASSERT_NEXT(a_std_x_write, clk, rst_n, cfg.valid && cfg.index == REG_STD_X, std_x_reg == $past(cfg.data))
    `BMG_ASSERT_IMPL(a_bubble_accepts, clk, rst_n, !vld_reg[AX_LAT-1], uniform.ready)

endmodule

`default_nettype wire
